@@ hdl/ime_pkg.sv @@
package ime_pkg;

   localparam int OP_W     = 2;
   localparam int ROW_W    = 4;
   localparam int DIDX_W   = 6;
   localparam int ELEM_W   = 8;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int SUM_W    = 22;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int ROWCNT_W   = 5;
   localparam int DEPTH_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROW_COUNT = 2'd0,
      CSR_B_ROW_COUNT = 2'd1,
      CSR_DEPTH       = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage

@@ hdl/ime_req_if.sv @@
interface ime_req_if import ime_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [ROW_W-1:0]         a_row;
   logic [ROW_W-1:0]         b_row;
   logic [DIDX_W-1:0]        depth_index;
   logic signed [ELEM_W-1:0] element;

   modport source (
      output valid, operation, a_row, b_row, depth_index, element,
      input  ready
   );

   modport sink (
      input  valid, operation, a_row, b_row, depth_index, element,
      output ready
   );
endinterface

@@ hdl/ime_rsp_if.sv @@
interface ime_rsp_if import ime_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] product_sum;
   logic                    row_error;

   modport source (
      output valid, product_sum, row_error,
      input  ready
   );

   modport sink (
      input  valid, product_sum, row_error,
      output ready
   );
endinterface

@@ hdl/int8_matrix_multiply_engine.sv @@
// Signed int8 matrix engine: C = A times B-transposed with a 22-bit wrapped sum. Load items
// (operation 0 or 1) write one element into the A or B store at their transfer;
// they produce no result and out-of-range loads are dropped. A compute item (operation 2)
// streams one A/B element pair per cycle from the two stores through one shared 8x8
// multiplier and accumulator; the input stays not ready from its transfer until its result
// enters the output register (the store walk is skipped when depth is zero or a row is out
// of range), and longer while an earlier result still waits there. It returns one result,
// with row_error set and a zero sum if either row is at or beyond its configured count.
// A finished result sits in an output register, so loads are taken while it waits.
// Stores are not cleared at reset: compute only over written elements.
module int8_matrix_multiply_engine import ime_pkg::*; #(
   parameter int MAX_A_ROWS = 16,
   parameter int MAX_B_ROWS = 16,
   parameter int MAX_DEPTH  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   ime_req_if.sink               req_chan,
   ime_rsp_if.source             rsp_chan
);

   localparam int A_ENTRIES = MAX_A_ROWS * MAX_DEPTH;
   localparam int B_ENTRIES = MAX_B_ROWS * MAX_DEPTH;
   localparam int AAW = (A_ENTRIES > 1) ? $clog2(A_ENTRIES) : 1;
   localparam int BAW = (B_ENTRIES > 1) ? $clog2(B_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_DEPTH + 1);
   localparam int EW  = (CW > DEPTH_W) ? CW : DEPTH_W;

   // configuration
   logic [ROWCNT_W-1:0] a_row_count_ff, a_row_count_in;
   logic [ROWCNT_W-1:0] b_row_count_ff, b_row_count_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;

   // sequencer
   state_type         state_ff, state_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     k_next;
   logic [AAW-1:0]    a_addr_ff, a_addr_in;
   logic [BAW-1:0]    b_addr_ff, b_addr_in;
   logic              err_ff, err_in;

   // datapath
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic                     rd_vld_ff, rd_vld_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     mul_vld_ff, mul_vld_in;
   logic [SUM_W-1:0]         acc_ff, acc_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic                rsp_err_ff, rsp_err_in;

   // stores
   logic [ELEM_W-1:0] a_mem [A_ENTRIES];
   logic [ELEM_W-1:0] b_mem [B_ENTRIES];

   logic           req_xfer;
   logic           a_row_ok, b_row_ok, didx_ok;
   logic           ld_a_we, ld_b_we;
   logic [AAW-1:0] ld_a_addr, a_base;
   logic [BAW-1:0] ld_b_addr, b_base;
   logic           last_k;

   assign req_xfer = req_chan.valid && req_chan.ready;

   assign a_row_ok = ({1'b0, req_chan.a_row} < a_row_count_ff) &&
                     (32'(req_chan.a_row) < MAX_A_ROWS);
   assign b_row_ok = ({1'b0, req_chan.b_row} < b_row_count_ff) &&
                     (32'(req_chan.b_row) < MAX_B_ROWS);
   assign didx_ok  = ({1'b0, req_chan.depth_index} < depth_ff) &&
                     (32'(req_chan.depth_index) < MAX_DEPTH);

   assign a_base    = AAW'(32'(req_chan.a_row) * MAX_DEPTH);
   assign b_base    = BAW'(32'(req_chan.b_row) * MAX_DEPTH);
   assign ld_a_addr = AAW'(32'(req_chan.a_row) * MAX_DEPTH + 32'(req_chan.depth_index));
   assign ld_b_addr = BAW'(32'(req_chan.b_row) * MAX_DEPTH + 32'(req_chan.depth_index));

   assign ld_a_we = req_xfer && (req_chan.operation == OP_LOAD_A) && a_row_ok && didx_ok;
   assign ld_b_we = req_xfer && (req_chan.operation == OP_LOAD_B) && b_row_ok && didx_ok;

   assign k_next = k_ff + CW'(1);
   assign last_k = (EW'(k_next) == EW'(depth_ff)) || (EW'(k_next) == EW'(MAX_DEPTH));

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.product_sum = rsp_sum_ff;
   assign rsp_chan.row_error   = rsp_err_ff;

   // store ports: one write, one registered read each
   always_ff @(posedge clock) begin
      if (ld_a_we) begin
         a_mem[ld_a_addr] <= req_chan.element;
      end
      if (ld_b_we) begin
         b_mem[ld_b_addr] <= req_chan.element;
      end
      a_rd_ff <= a_mem[a_addr_ff];
      b_rd_ff <= b_mem[b_addr_ff];
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   always_comb begin
      a_row_count_in = a_row_count_ff;
      b_row_count_in = b_row_count_ff;
      depth_in       = depth_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_A_ROW_COUNT: a_row_count_in = csr_data[ROWCNT_W-1:0];
            CSR_B_ROW_COUNT: b_row_count_in = csr_data[ROWCNT_W-1:0];
            CSR_DEPTH:       depth_in       = csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      a_addr_in    = a_addr_ff;
      b_addr_in    = b_addr_ff;
      err_in       = err_ff;
      rd_vld_in    = 1'b0;
      mul_vld_in   = rd_vld_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;

      if (mul_vld_ff) begin
         acc_in = acc_ff + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_chan.operation == OP_COMPUTE)) begin
               acc_in    = '0;
               k_in      = '0;
               a_addr_in = a_base;
               b_addr_in = b_base;
               err_in    = !(a_row_ok && b_row_ok);
               if (!(a_row_ok && b_row_ok) || (depth_ff == '0)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            // one pair read per cycle
            rd_vld_in = 1'b1;
            k_in      = k_next;
            a_addr_in = a_addr_ff + AAW'(1);
            b_addr_in = b_addr_ff + BAW'(1);
            if (last_k) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = err_ff ? '0 : acc_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_row_count_ff <= ROWCNT_W'(16);
         b_row_count_ff <= ROWCNT_W'(16);
         depth_ff       <= DEPTH_W'(64);
         state_ff       <= S_IDLE;
         rd_vld_ff      <= 1'b0;
         mul_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         a_row_count_ff <= a_row_count_in;
         b_row_count_ff <= b_row_count_in;
         depth_ff       <= depth_in;
         state_ff       <= state_in;
         rd_vld_ff      <= rd_vld_in;
         mul_vld_ff     <= mul_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      a_addr_ff  <= a_addr_in;
      b_addr_ff  <= b_addr_in;
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
   end

`ifndef NO_ASSERTIONS
   // an error result never carries a sum
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.row_error |-> rsp_chan.product_sum == '0)
      else $error("row error result with nonzero sum");

   // pipeline is empty before the result is taken from the accumulator
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !rd_vld_ff && !mul_vld_ff)
      else $error("result formed before multiply pipeline drained");

   // out-of-range compute skips the store walk
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_chan.operation == OP_COMPUTE) && !(a_row_ok && b_row_ok)
      |=> state_ff == S_DONE)
      else $error("row error compute entered the accumulate loop");

   // reads are only issued while the sequencer walks the row
   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff) == S_RUN)
      else $error("store read outside of run state");
`endif

endmodule
